### hdl/dqlm_pkg.sv
// shared constants and types for the dns query latency monitor
package dqlm_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	localparam logic [15:0] ETH_IPV4 = 16'h0800;
	localparam logic [15:0] ETH_IPV6 = 16'h86DD;
	localparam logic [7:0] IP_UDP = 8'h11;
	localparam logic [15:0] DNS_PORT_RESET = 16'd53;
	localparam logic [15:0] IPV4_DNS_OFS = 16'd42;
	localparam logic [15:0] IPV6_DNS_OFS = 16'd62;
	localparam logic [15:0] DNS_HDR_LEN = 16'd12;
	localparam int FLAG_RESPONSE = 15;

	localparam logic signed [20:0] MICROS_PER_SEC = 21'sd1000000;
	localparam logic signed [47:0] DELAY_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] DELAY_MIN = 48'sh8000_0000_0000;

	typedef logic [3:0] status_t;
	localparam status_t ST_NOT_IP = 4'd0;
	localparam status_t ST_NOT_UDP = 4'd1;
	localparam status_t ST_NOT_DNS = 4'd2;
	localparam status_t ST_TRUNCATED = 4'd3;
	localparam status_t ST_MULTI_Q = 4'd4;
	localparam status_t ST_STORED = 4'd5;
	localparam status_t ST_FULL = 4'd6;
	localparam status_t ST_MATCHED = 4'd7;
	localparam status_t ST_UNKNOWN = 4'd8;

	typedef struct packed {
		logic [15:0] ident;
		logic [31:0] secs;
		logic [19:0] micros;
		logic [47:0] order;
	} entry_t;

	typedef struct packed {
		logic wr_en;
		logic clr_en;
		logic [IDX_W-1:0] idx;
		entry_t entry;
	} tbl_cmd_t;

endpackage

### hdl/dqlm_table.sv
// pending query table: entry memory with registered read and pending flags
module dqlm_table import dqlm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_idx,
	output entry_t           rd_entry,
	output logic             rd_pend,
	input  tbl_cmd_t         cmd
);

	entry_t mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] pend_q;
	entry_t rd_entry_q;
	logic rd_pend_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.idx] <= cmd.entry;
		end
		if (rd_en) begin
			rd_entry_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			if (cmd.wr_en) begin
				pend_q[cmd.idx] <= 1'b1;
			end
			if (cmd.clr_en) begin
				pend_q[cmd.idx] <= 1'b0;
			end
			if (rd_en) begin
				rd_pend_q <= pend_q[rd_idx];
			end
		end
	end

	assign rd_entry = rd_entry_q;
	assign rd_pend = rd_pend_q;

endmodule

### hdl/dqlm_delay.sv
// three stage delay unit: time difference, scale to microseconds, add and saturate
module dqlm_delay import dqlm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [31:0]        secs_new,
	input  logic [31:0]        secs_old,
	input  logic [19:0]        micros_new,
	input  logic [19:0]        micros_old,
	output logic               done,
	output logic signed [47:0] delay
);

	logic vld_s1, vld_s2, vld_s3;
	logic signed [32:0] ds_s1;
	logic signed [20:0] du_s1, du_s2;
	logic signed [53:0] prod_s2;
	logic signed [47:0] delay_s3;
	logic signed [54:0] sum;

	assign sum = 55'(prod_s2) + 55'(du_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		ds_s1 <= $signed({1'b0, secs_new}) - $signed({1'b0, secs_old});
		du_s1 <= $signed({1'b0, micros_new}) - $signed({1'b0, micros_old});
		prod_s2 <= 54'(ds_s1) * 54'(MICROS_PER_SEC);
		du_s2 <= du_s1;
		if (sum > 55'(DELAY_MAX)) begin
			delay_s3 <= DELAY_MAX;
		end else if (sum < 55'(DELAY_MIN)) begin
			delay_s3 <= DELAY_MIN;
		end else begin
			delay_s3 <= sum[47:0];
		end
	end

	assign done = vld_s3;
	assign delay = delay_s3;

endmodule

### hdl/dns_query_latency_monitor_unit.sv
// dns query latency monitor top level: classifier, table scan sequencer, statistics
//
// usage
//   config: cfg_valid/cfg_ready write channel, cfg_data is the dns port; always ready,
//   write only while the block is idle
//   input: one word per captured packet header on in_valid, taken when in_stall is low
//   output: one result word per input on out_valid, taken when out_stall is low
// sequencing
//   skipped packets: no table scan; the done state writes the result register
//   queries and unknown replies: a scan of all 16 table entries, then the drain and
//   decide states, then the done state writes the result register
//   matched replies: the delay unit pipeline runs between the decide and done states
//   the scan of the pending table through its single read port sets the rate; one
//   item is in work at a time and in_stall is high until it finishes
// reset
//   arst_n clears pending flags and counters; dns port to 53, min to DELAY_MAX, max to -1
// receiver stall
//   a finished result waits in the output register; the next packet may be taken
//   and processed, but its result waits until the output register is free
module dns_query_latency_monitor_unit import dqlm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        ethertype,
	input  logic [7:0]         ip_protocol,
	input  logic [15:0]        source_port,
	input  logic [15:0]        dest_port,
	input  logic [15:0]        captured_length,
	input  logic [15:0]        dns_flags,
	input  logic [15:0]        question_count,
	input  logic [15:0]        transaction_id,
	input  logic [31:0]        time_seconds,
	input  logic [19:0]        time_micros,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         status,
	output logic signed [47:0] delay_us,
	output logic signed [47:0] min_delay_us,
	output logic signed [47:0] max_delay_us,
	output logic [47:0]        queries_seen,
	output logic [47:0]        replies_matched
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DECIDE,
		S_CALC,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		K_SKIP,
		K_QUERY,
		K_REPLY
	} kind_t;

	state_t state_q;
	kind_t kind_q;
	status_t skip_status_q;
	logic [15:0] dns_port_q;
	logic [15:0] ident_q;
	logic [31:0] secs_q;
	logic [19:0] micros_q;
	logic [IDX_W-1:0] idx_q;
	logic rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic found_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [47:0] best_age_q;
	logic [31:0] best_secs_q;
	logic [19:0] best_micros_q;
	logic signed [47:0] delay_q;
	logic [47:0] query_total_q, reply_total_q;
	logic signed [47:0] min_delay_q, max_delay_q;

	logic out_valid_q;
	status_t out_status_q;
	logic signed [47:0] out_delay_q, out_min_q, out_max_q;
	logic [47:0] out_queries_q, out_replies_q;

	// classifier
	logic accept, is_v4, is_v6, dns_hit, is_resp;
	logic [15:0] len_limit;
	kind_t cls_kind;
	status_t cls_status;

	assign accept = in_valid && !in_stall;
	assign is_v4 = (ethertype == ETH_IPV4);
	assign is_v6 = (ethertype == ETH_IPV6);
	assign dns_hit = (source_port == dns_port_q) || (dest_port == dns_port_q);
	assign is_resp = dns_flags[FLAG_RESPONSE];
	assign len_limit = (is_v6 ? IPV6_DNS_OFS : IPV4_DNS_OFS) + DNS_HDR_LEN;

	always_comb begin
		cls_kind = K_SKIP;
		cls_status = ST_NOT_IP;
		if (!is_v4 && !is_v6) begin
			cls_status = ST_NOT_IP;
		end else if (ip_protocol != IP_UDP) begin
			cls_status = ST_NOT_UDP;
		end else if (!dns_hit) begin
			cls_status = ST_NOT_DNS;
		end else if (captured_length <= len_limit) begin
			cls_status = ST_TRUNCATED;
		end else if (is_resp) begin
			cls_kind = K_REPLY;
		end else if (question_count != 16'd1) begin
			cls_status = ST_MULTI_Q;
		end else begin
			cls_kind = K_QUERY;
		end
	end

	// table and scan
	entry_t rd_entry;
	logic rd_pend, rd_en;
	tbl_cmd_t tbl_cmd;
	logic [47:0] age;
	logic take;

	assign rd_en = (state_q == S_SCAN);
	assign age = query_total_q - rd_entry.order;

	always_comb begin
		take = 1'b0;
		if (rd_vld_s1) begin
			if (kind_q == K_QUERY) begin
				take = !rd_pend && !found_q;
			end else if (kind_q == K_REPLY) begin
				take = rd_pend && (rd_entry.ident == ident_q) &&
					(!found_q || (age < best_age_q));
			end
		end
	end

	dqlm_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_idx   (idx_q),
		.rd_entry (rd_entry),
		.rd_pend  (rd_pend),
		.cmd      (tbl_cmd)
	);

	// delay unit
	logic calc_start, calc_done;
	logic signed [47:0] calc_delay;

	assign calc_start = (state_q == S_DECIDE) && (kind_q == K_REPLY) && found_q;

	dqlm_delay u_delay (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (calc_start),
		.secs_new   (secs_q),
		.secs_old   (best_secs_q),
		.micros_new (micros_q),
		.micros_old (best_micros_q),
		.done       (calc_done),
		.delay      (calc_delay)
	);

	// result and statistics update
	logic out_free, done_fire;
	status_t res_status;
	logic signed [47:0] res_delay, min_nx, max_nx;
	logic [47:0] query_nx, reply_nx;

	assign out_free = !out_valid_q || !out_stall;
	assign done_fire = (state_q == S_DONE) && out_free;

	always_comb begin
		res_status = skip_status_q;
		res_delay = '0;
		query_nx = query_total_q;
		reply_nx = reply_total_q;
		min_nx = min_delay_q;
		max_nx = max_delay_q;
		unique case (kind_q)
			K_QUERY: begin
				res_status = found_q ? ST_STORED : ST_FULL;
				query_nx = query_total_q + 48'd1;
			end
			K_REPLY: begin
				if (found_q) begin
					res_status = ST_MATCHED;
					res_delay = delay_q;
					reply_nx = reply_total_q + 48'd1;
					if (delay_q < min_delay_q) begin
						min_nx = delay_q;
					end
					if (delay_q > max_delay_q) begin
						max_nx = delay_q;
					end
				end else begin
					res_status = ST_UNKNOWN;
				end
			end
			default: begin
				res_status = skip_status_q;
			end
		endcase
	end

	always_comb begin
		tbl_cmd.wr_en = done_fire && (kind_q == K_QUERY) && found_q;
		tbl_cmd.clr_en = done_fire && (kind_q == K_REPLY) && found_q;
		tbl_cmd.idx = best_idx_q;
		tbl_cmd.entry.ident = ident_q;
		tbl_cmd.entry.secs = secs_q;
		tbl_cmd.entry.micros = micros_q;
		tbl_cmd.entry.order = query_total_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q <= K_SKIP;
			dns_port_q <= DNS_PORT_RESET;
			idx_q <= '0;
			rd_vld_s1 <= 1'b0;
			found_q <= 1'b0;
			query_total_q <= '0;
			reply_total_q <= '0;
			min_delay_q <= DELAY_MAX;
			max_delay_q <= -48'sd1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				dns_port_q <= cfg_data;
			end
			rd_vld_s1 <= rd_en;
			if (take) begin
				found_q <= 1'b1;
			end
			if (done_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q <= cls_kind;
						found_q <= 1'b0;
						idx_q <= '0;
						state_q <= (cls_kind == K_SKIP) ? S_DONE : S_SCAN;
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IDX_W'(TABLE_ENTRIES - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= calc_start ? S_CALC : S_DONE;
				end
				S_CALC: begin
					if (calc_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						query_total_q <= query_nx;
						reply_total_q <= reply_nx;
						min_delay_q <= min_nx;
						max_delay_q <= max_nx;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			skip_status_q <= cls_status;
			ident_q <= transaction_id;
			secs_q <= time_seconds;
			micros_q <= time_micros;
		end
		rd_idx_s1 <= idx_q;
		if (take) begin
			best_idx_q <= rd_idx_s1;
			best_age_q <= age;
			best_secs_q <= rd_entry.secs;
			best_micros_q <= rd_entry.micros;
		end
		if (calc_done) begin
			delay_q <= calc_delay;
		end
		if (done_fire) begin
			out_status_q <= res_status;
			out_delay_q <= res_delay;
			out_min_q <= min_nx;
			out_max_q <= max_nx;
			out_queries_q <= query_nx;
			out_replies_q <= reply_nx;
		end
	end

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign delay_us = out_delay_q;
	assign min_delay_us = out_min_q;
	assign max_delay_us = out_max_q;
	assign queries_seen = out_queries_q;
	assign replies_matched = out_replies_q;

`ifndef NO_ASSERTIONS
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (state_q == S_IDLE))
		else $error("packet taken while sequencer busy");

	a_match_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done_fire && (res_status == ST_MATCHED)) |=>
		(replies_matched == $past(reply_total_q) + 48'd1))
		else $error("matched reply did not advance reply count");

	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		(reply_total_q != '0) |-> (min_delay_q <= max_delay_q))
		else $error("min delay above max delay");

	a_delay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_MATCHED)) |-> (delay_us == '0))
		else $error("delay reported on unmatched word");

	a_calc_only_reply: assert property (@(posedge clk) disable iff (!arst_n)
		calc_done |-> ((state_q == S_CALC) && (kind_q == K_REPLY)))
		else $error("delay unit finished outside a reply");
`endif

endmodule
